// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL that checks itself.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

// ===== hdl/dtmf_pkg.sv =====
// Constants, types and helper functions of the DTMF dual-tone sample generator.
// The sine quarter-wave table is built here at elaboration; no other dependencies.
package dtmf_pkg;

  localparam int PHASE_BITS = 10;
  localparam int QUARTER    = 1 << (PHASE_BITS - 2);
  localparam int ADDR_W     = PHASE_BITS - 1;
  localparam int AMP_W      = 14;
  localparam int TONE_W     = 4;
  localparam int TICK_W     = 32;
  localparam int RATE_W     = 17;
  localparam int SAMPLE_W   = 16;
  localparam int FREQ_W     = 11;
  localparam int PROD_W     = TICK_W + FREQ_W;

  // Long division of {tick * freq, PHASE_BITS zeros} by the clock rate.
  localparam int DIV_BITS   = PROD_W + PHASE_BITS;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (DIV_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DVD_W      = DIV_STAGES * DIV_STEPS;

  localparam logic [RATE_W-1:0] RATE_RESET  = RATE_W'(8000);
  localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0]       AMPLITUDE   = 64'd16383;

  typedef logic [3:0][FREQ_W-1:0] freq_tab_t;
  typedef logic [15:0][1:0]       key_tab_t;

  localparam freq_tab_t ROW_HZ = {11'd941, 11'd852, 11'd770, 11'd697};
  localparam freq_tab_t COL_HZ = {11'd1633, 11'd1477, 11'd1336, 11'd1209};

  // Listed from key 15 down to key 0.
  localparam key_tab_t KEY_ROW = {2'd3, 2'd2, 2'd1, 2'd0, 2'd3, 2'd3, 2'd2, 2'd2,
                                  2'd2, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd3};
  localparam key_tab_t KEY_COL = {2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd0, 2'd2, 2'd1,
                                  2'd0, 2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd1};

  // One lane of the division pipeline: partial remainder, dividend bits not
  // yet consumed (MSB first), and the most recent quotient bits.
  typedef struct packed {
    logic [RATE_W-1:0]     rem;
    logic [DVD_W-1:0]      dvd;
    logic [PHASE_BITS-1:0] quot;
  } div_lane_t;

  typedef logic [QUARTER:0][AMP_W-1:0] sine_rom_t;

  // Restoring division steps for one pipeline stage. The remainder stays
  // below the rate, so the trial value never needs more than one extra bit.
  function automatic div_lane_t div_steps(div_lane_t cur, logic [RATE_W-1:0] rate);
    div_lane_t         nxt;
    logic [RATE_W:0]   trial;
    nxt = cur;
    for (int s = 0; s < DIV_STEPS; s++) begin
      trial   = {nxt.rem, nxt.dvd[DVD_W-1]};
      nxt.dvd = {nxt.dvd[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, rate}) begin
        nxt.rem  = RATE_W'(trial - {1'b0, rate});
        nxt.quot = {nxt.quot[PHASE_BITS-2:0], 1'b1};
      end else begin
        nxt.rem  = trial[RATE_W-1:0];
        nxt.quot = {nxt.quot[PHASE_BITS-2:0], 1'b0};
      end
    end
    return nxt;
  endfunction

  // Quarter-wave sine table, evaluated once at elaboration with a Q2.30
  // Taylor series up to the eleventh power, scaled and rounded half up.
  function automatic sine_rom_t sine_rom_init();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    for (int k = 0; k <= QUARTER; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) >> (PHASE_BITS - 2);
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      // Dividing by 2n(2n+1) * 2^30 equals a shift by 30 and then the small divisor.
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      if (sum < 0) begin
        sum = 0;
      end
      sum = (sum * $signed(AMPLITUDE) + (64'sd1 <<< 29)) >>> 30;
      if (sum > $signed(AMPLITUDE)) begin
        sum = $signed(AMPLITUDE);
      end
      rom[k] = AMP_W'(sum);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = sine_rom_init();

endpackage

// ===== hdl/dtmf_dual_tone_sample_generator_unit.sv =====
// Top level of the DTMF dual-tone sample generator: a fully pipelined datapath.
// Depends on dtmf_pkg and on assert_macros.svh for its checks.
`include "assert_macros.svh"

// Usage
// - Input channel (in_valid/in_ready): one beat carries a key code, a sample
//   tick and a last-of-block flag. Output channel (out_valid/out_ready): one
//   beat carries the signed sample and the copied last flag, in input order.
// - Config channel (cfg_valid/cfg_ready): writes the sample clock rate in
//   hertz. cfg_ready is always high; write only while no beat is in flight.
// - A beat passes the input, multiplier, division, address, table read
//   and output stages in order. Throughput is one beat per cycle unless
//   the receiver stalls a full pipeline; the depth is set by the long
//   division of tick * freq by the clock rate, which retires four quotient bits per stage.
// - A clock rate of zero gives a sample of zero.
// - Reset clears all stage valid bits and loads a clock rate of 8000 Hz.
// - When the receiver stalls, the stages behind the output register keep
//   moving until they fill, so in_ready stays high while any stage is empty.
//   in_ready drops only when every stage holds a beat and out_ready is low.
module dtmf_dual_tone_sample_generator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dtmf_pkg::RATE_W-1:0]        cfg_clock_rate,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dtmf_pkg::TONE_W-1:0]        in_tone,
  input  logic [dtmf_pkg::TICK_W-1:0]        in_tick,
  input  logic                               in_last_of_block,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [dtmf_pkg::SAMPLE_W-1:0] out_sample,
  output logic                               out_last
);
  import dtmf_pkg::*;

  localparam int ST_IN      = 0;
  localparam int ST_MUL     = 1;
  localparam int ST_ADDR    = ST_MUL + DIV_STAGES + 1;
  localparam int ST_ROM     = ST_ADDR + 1;
  localparam int ST_OUT     = ST_ROM + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  logic [RATE_W-1:0]     rate_r;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] last_r;
  logic [NUM_STAGES-1:0] last_nxt;
  logic [NUM_STAGES-1:0] en;

  logic [TICK_W-1:0]     tick_r;
  logic [FREQ_W-1:0]     row_hz_r;
  logic [FREQ_W-1:0]     col_hz_r;
  logic [FREQ_W-1:0]     row_hz_nxt;
  logic [FREQ_W-1:0]     col_hz_nxt;

  // Index 0 is the multiplier stage, index j the j-th division stage.
  div_lane_t             row_div_r   [DIV_STAGES+1];
  div_lane_t             col_div_r   [DIV_STAGES+1];
  div_lane_t             row_div_nxt [DIV_STAGES+1];
  div_lane_t             col_div_nxt [DIV_STAGES+1];

  logic [ADDR_W-1:0]     row_addr_r;
  logic [ADDR_W-1:0]     col_addr_r;
  logic [ADDR_W-1:0]     row_addr_nxt;
  logic [ADDR_W-1:0]     col_addr_nxt;
  logic                  row_neg_r;
  logic                  col_neg_r;

  logic [AMP_W-1:0]      row_mag_r;
  logic [AMP_W-1:0]      col_mag_r;
  logic                  row_neg_rom_r;
  logic                  col_neg_rom_r;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] sample_nxt;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rate_r <= cfg_clock_rate;
    end
  end

  // A stage advances when it is empty, when some stage ahead of it is empty,
  // or when the output register is being drained.
  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_en
    assign en[g] = out_ready || !(&vld_r[NUM_STAGES-1:g]);
  end

  assign vld_nxt  = {vld_r[NUM_STAGES-2:0], in_valid};
  assign last_nxt = {last_r[NUM_STAGES-2:0], in_last_of_block};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= (en & vld_nxt) | (~en & vld_r);
    end
  end

  always_ff @(posedge clk) begin
    last_r <= (en & last_nxt) | (~en & last_r);
  end

  assign in_ready = en[ST_IN];

  // Input stage: decode the key into its row and column frequencies.
  assign row_hz_nxt = ROW_HZ[KEY_ROW[in_tone]];
  assign col_hz_nxt = COL_HZ[KEY_COL[in_tone]];

  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      tick_r   <= in_tick;
      row_hz_r <= row_hz_nxt;
      col_hz_r <= col_hz_nxt;
    end
  end

  // Multiplier stage: the dividend is the product followed by PHASE_BITS
  // zeros, so the last quotient bits of the division give the phase index.
  always_comb begin
    row_div_nxt[0].rem  = '0;
    row_div_nxt[0].quot = '0;
    row_div_nxt[0].dvd  = DVD_W'({PROD_W'(tick_r) * PROD_W'(row_hz_r),
                                  {PHASE_BITS{1'b0}}});
    col_div_nxt[0].rem  = '0;
    col_div_nxt[0].quot = '0;
    col_div_nxt[0].dvd  = DVD_W'({PROD_W'(tick_r) * PROD_W'(col_hz_r),
                                  {PHASE_BITS{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      row_div_r[0] <= row_div_nxt[0];
      col_div_r[0] <= col_div_nxt[0];
    end
  end

  // Division stages.
  for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
    assign row_div_nxt[g] = div_steps(row_div_r[g-1], rate_r);
    assign col_div_nxt[g] = div_steps(col_div_r[g-1], rate_r);

    always_ff @(posedge clk) begin
      if (en[ST_MUL+g]) begin
        row_div_r[g] <= row_div_nxt[g];
        col_div_r[g] <= col_div_nxt[g];
      end
    end
  end

  // Address stage: odd quadrants read the table backwards, the upper half
  // of the circle is negated later.
  always_comb begin
    if (row_div_r[DIV_STAGES].quot[PHASE_BITS-2]) begin
      row_addr_nxt = ADDR_W'(QUARTER) - ADDR_W'(row_div_r[DIV_STAGES].quot[PHASE_BITS-3:0]);
    end else begin
      row_addr_nxt = ADDR_W'(row_div_r[DIV_STAGES].quot[PHASE_BITS-3:0]);
    end
    if (col_div_r[DIV_STAGES].quot[PHASE_BITS-2]) begin
      col_addr_nxt = ADDR_W'(QUARTER) - ADDR_W'(col_div_r[DIV_STAGES].quot[PHASE_BITS-3:0]);
    end else begin
      col_addr_nxt = ADDR_W'(col_div_r[DIV_STAGES].quot[PHASE_BITS-3:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_ADDR]) begin
      row_addr_r <= row_addr_nxt;
      col_addr_r <= col_addr_nxt;
      row_neg_r  <= row_div_r[DIV_STAGES].quot[PHASE_BITS-1];
      col_neg_r  <= col_div_r[DIV_STAGES].quot[PHASE_BITS-1];
    end
  end

  // Table read stage.
  always_ff @(posedge clk) begin
    if (en[ST_ROM]) begin
      row_mag_r     <= SINE_ROM[row_addr_r];
      col_mag_r     <= SINE_ROM[col_addr_r];
      row_neg_rom_r <= row_neg_r;
      col_neg_rom_r <= col_neg_r;
    end
  end

  // Output stage: apply signs and add the two tones.
  always_comb begin
    logic signed [SAMPLE_W-1:0] row_val;
    logic signed [SAMPLE_W-1:0] col_val;
    row_val = SAMPLE_W'(row_mag_r);
    col_val = SAMPLE_W'(col_mag_r);
    if (row_neg_rom_r) begin
      row_val = -row_val;
    end
    if (col_neg_rom_r) begin
      col_val = -col_val;
    end
    if (rate_r == '0) begin
      sample_nxt = '0;
    end else begin
      sample_nxt = row_val + col_val;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      sample_r <= sample_nxt;
    end
  end

  assign out_valid  = vld_r[ST_OUT];
  assign out_sample = sample_r;
  assign out_last   = last_r[ST_OUT];

  // Checks.
  `ASSERT_IMPL(a_stall_only_when_full, !in_ready, out_valid && !out_ready && (&vld_r),
               "input stalled although a pipeline stage is empty")
  `ASSERT_CLK(a_accept_fills_first, (in_valid && in_ready) |=> vld_r[ST_IN],
              "accepted beat did not enter the first stage")
  `ASSERT_IMPL(a_addr_in_range, vld_r[ST_ADDR],
               (row_addr_r <= ADDR_W'(QUARTER)) && (col_addr_r <= ADDR_W'(QUARTER)),
               "sine table address beyond the quarter wave")
  `ASSERT_IMPL(a_sample_range, out_valid,
               (out_sample >= -16'sd32766) && (out_sample <= 16'sd32766),
               "output sample outside the two-tone range")

endmodule

// ===== tb/sv/dtmf_dual_tone_sample_generator_unit_tb.sv =====
// Self-checking testbench of the DTMF dual-tone sample generator unit.
// Predicts every sample from its own sine table and keypad tables; needs dtmf_pkg
// and the RTL of dtmf_dual_tone_sample_generator_unit.
`timescale 1ns / 1ps

module dtmf_dual_tone_sample_generator_unit_tb;

  localparam int          QUARTER_LEN = 1 << (dtmf_pkg::PHASE_BITS - 2);
  localparam int          DRAIN_CYCLES = 24;
  localparam int          QUIET_LIMIT = 2000;
  localparam int unsigned RATE_MAX = 17'h1FFFF;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } tone_sample_t;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [dtmf_pkg::RATE_W-1:0]          cfg_clock_rate;
  logic                                 in_valid;
  logic                                 in_ready;
  logic [dtmf_pkg::TONE_W-1:0]          in_tone;
  logic [dtmf_pkg::TICK_W-1:0]          in_tick;
  logic                                 in_last_of_block;
  logic                                 out_valid;
  logic                                 out_ready;
  logic signed [dtmf_pkg::SAMPLE_W-1:0] out_sample;
  logic                                 out_last;

  int unsigned                 row_freq [4] = '{697, 770, 852, 941};
  int unsigned                 col_freq [4] = '{1209, 1336, 1477, 1633};
  int unsigned                 key_row [16] = '{3, 0, 0, 0, 1, 1, 1, 2, 2, 2, 3, 3, 0, 1, 2, 3};
  int unsigned                 key_col [16] = '{1, 0, 1, 2, 0, 1, 2, 0, 1, 2, 0, 2, 3, 3, 3, 3};
  int                          sine_lut [QUARTER_LEN+1];
  logic [dtmf_pkg::RATE_W-1:0] clock_rate_hz;
  tone_sample_t                sample_q [$];
  bit                          idle_en;
  int                          fail_count;
  int                          quiet_cycles;

  dtmf_dual_tone_sample_generator_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_clock_rate   (cfg_clock_rate),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_tone          (in_tone),
    .in_tick          (in_tick),
    .in_last_of_block (in_last_of_block),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample       (out_sample),
    .out_last         (out_last)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Quarter-wave sine in Q2.30 by a Taylor series, scaled to 16383, rounded half up.
  function automatic int sine_quarter(int unsigned k);
    longint unsigned ang;
    longint unsigned ang2;
    longint unsigned term;
    longint unsigned den;
    longint          acc;
    ang  = (64'd1686629713 * longint'(k)) / longint'(QUARTER_LEN);
    ang2 = (ang * ang) >> 30;
    term = ang;
    acc  = longint'(ang);
    for (int n = 1; n <= 5; n++) begin
      den  = longint'((2 * n) * (2 * n + 1)) << 30;
      term = (term * ang2) / den;
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc * 16383 + 64'sd536870912) / 64'sd1073741824;
    if (acc > 16383) begin
      acc = 16383;
    end
    return int'(acc);
  endfunction

  function automatic int tone_level(logic [31:0] tick, int unsigned freq);
    longint unsigned rem;
    longint unsigned idx;
    longint unsigned rate;
    int unsigned     quad;
    int unsigned     off;
    rate = longint'(clock_rate_hz);
    if (rate == 0) begin
      return 0;
    end
    rem  = (longint'(tick) * longint'(freq)) % rate;
    idx  = (rem << dtmf_pkg::PHASE_BITS) / rate;
    quad = int'((idx / QUARTER_LEN) % 4);
    off  = int'(idx % QUARTER_LEN);
    case (quad)
      0: return sine_lut[off];
      1: return sine_lut[QUARTER_LEN - off];
      2: return -sine_lut[off];
      default: return -sine_lut[QUARTER_LEN - off];
    endcase
  endfunction

  function automatic logic signed [15:0] dual_tone_sample(logic [3:0] key, logic [31:0] tick);
    int level;
    level = tone_level(tick, row_freq[key_row[key]]) + tone_level(tick, col_freq[key_col[key]]);
    return 16'(level);
  endfunction

  // Called just after a rising edge; returns just after the edge that accepts the beat.
  task automatic send_beat(logic [3:0] key, logic [31:0] tick, logic last);
    while (idle_en && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_tone          <= key;
    in_tick          <= tick;
    in_last_of_block <= last;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    sample_q.push_back('{dual_tone_sample(key, tick), last});
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sample_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_rate(logic [dtmf_pkg::RATE_W-1:0] rate);
    wait_drained();
    cfg_valid      <= 1'b1;
    cfg_clock_rate <= rate;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid     <= 1'b0;
    clock_rate_hz = rate;
  endtask

  // Every key once at the reset rate, plus the tick extremes.
  task automatic test_keypad_at_reset_rate();
    for (int k = 0; k < 16; k++) begin
      send_beat(4'(k), 32'(k * 37 + 1), k[0]);
    end
    send_beat(4'd0, 32'd0, 1'b0);
    send_beat(4'd15, 32'hFFFF_FFFF, 1'b1);
  endtask

  // A zero rate silences both tones; rates outside the audio range are used as written.
  task automatic test_rate_extremes();
    write_rate('0);
    send_beat(4'd5, 32'h1234_5678, 1'b0);
    send_beat(4'd12, 32'hFFFF_FFFF, 1'b1);
    write_rate(RATE_MAX[dtmf_pkg::RATE_W-1:0]);
    send_beat(4'd9, 32'hFFFF_FFFF, 1'b1);
    send_beat(4'd10, 32'hA5A5_A5A5, 1'b0);
    write_rate(17'd1);
    send_beat(4'd11, 32'h8000_0001, 1'b1);
    write_rate(17'd1000);
    send_beat(4'd3, 32'd3, 1'b0);
  endtask

  // Mostly blocks of consecutive ticks for one key, with a stray beat now and then.
  task automatic run_tone_blocks(int unsigned n_beats);
    int unsigned sent;
    int unsigned blk_len;
    logic [3:0]  key;
    logic [31:0] start;
    sent = 0;
    while (sent < n_beats) begin
      if ($urandom_range(9) == 0) begin
        send_beat(4'($urandom), $urandom, 1'($urandom_range(1)));
        sent++;
      end else begin
        key     = 4'($urandom);
        blk_len = $urandom_range(1, 24);
        case ($urandom_range(2))
          0: start = $urandom_range(63);
          1: start = $urandom;
          default: start = 32'hFFFF_FFFF - $urandom_range(15);
        endcase
        for (int unsigned i = 0; i < blk_len; i++) begin
          send_beat(key, start + i, i == blk_len - 1);
        end
        sent += blk_len;
      end
    end
  endtask

  task automatic test_random_traffic();
    int unsigned rates [7];
    rates = '{8000, 1000, 96000, 44100, $urandom_range(1000, 96000),
              $urandom_range(0, RATE_MAX), 1};
    for (int p = 0; p < 7; p++) begin
      write_rate(rates[p][dtmf_pkg::RATE_W-1:0]);
      // The third phase runs with both sides always ready.
      idle_en = (p != 2);
      run_tone_blocks(170);
    end
    idle_en = 1'b1;
  endtask

  always @(posedge clk) begin
    out_ready <= !idle_en || ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    tone_sample_t exp_beat;
    if (rst_n && out_valid && out_ready) begin
      if (sample_q.size() == 0) begin
        $display("%0t unexpected beat: sample %0d last %0b", $time, out_sample, out_last);
        fail_count++;
      end else begin
        exp_beat = sample_q.pop_front();
        if (out_sample !== exp_beat.sample) begin
          $display("%0t sample mismatch: expected %0d actual %0d",
                   $time, exp_beat.sample, out_sample);
          fail_count++;
        end
        if (out_last !== exp_beat.last) begin
          $display("%0t last mismatch: expected %0b actual %0b",
                   $time, exp_beat.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // Ends the run when no channel has moved a beat for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("dtmf_dual_tone_sample_generator_unit_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_clock_rate   = '0;
    in_valid         = 1'b0;
    in_tone          = '0;
    in_tick          = '0;
    in_last_of_block = 1'b0;
    out_ready        = 1'b0;
    idle_en          = 1'b1;
    fail_count       = 0;
    quiet_cycles     = 0;
    clock_rate_hz    = 17'd8000;
    for (int k = 0; k <= QUARTER_LEN; k++) begin
      sine_lut[k] = sine_quarter(k);
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_keypad_at_reset_rate();
    test_rate_extremes();
    test_random_traffic();
    wait_drained();
    if (fail_count == 0 && sample_q.size() == 0) begin
      $display("dtmf_dual_tone_sample_generator_unit_tb OK");
    end else begin
      $display("dtmf_dual_tone_sample_generator_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
